@@ design/rtd_temperature_linearizer_core_assert.svh @@
// Assertion macros used by the linearizer top level.
`ifndef RTD_TEMPERATURE_LINEARIZER_CORE_ASSERT_SVH
`define RTD_TEMPERATURE_LINEARIZER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define RTDLIN_ASSERT_IMP(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("rtd linearizer: implication check failed");

// Next-cycle implication, disabled while reset is held.
`define RTDLIN_ASSERT_NXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("rtd linearizer: next-cycle check failed");

`endif

@@ design/rtd_lin_pkg.sv @@
// Package with types, constants, the calibration table and the microcode ROM.
package rtd_lin_pkg;

  localparam int TABLE_POINTS = 12;
  localparam int IDX_W        = $clog2(TABLE_POINTS);
  localparam int CODE_W       = 16;
  localparam int TEMP_W       = 21;
  localparam int VOLT_W       = 15;
  localparam int SC_W         = 29;
  localparam int DIFF_W       = 27;
  localparam int DT_W         = 13;
  localparam int DV_W         = 12;
  localparam int PROD_W       = 40;
  localparam int QUO_W        = 16;
  localparam int CNT_W        = 4;
  localparam int PC_W         = 4;
  localparam int VOLT_SHIFT   = 11;

  // 33000 / 8: both sides of every voltage compare are scaled down by 8.
  localparam logic [12:0]       VOLT_SCALE = 13'd4125;
  localparam logic [CODE_W-1:0] CODE_FULL  = 16'd16384;
  localparam logic signed [TEMP_W-1:0] OOR_TEMP = 21'sd999900;
  localparam logic [CNT_W-1:0]  DIV_LAST   = 4'd15;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [PC_W-1:0]  pc_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_SCALE,
    OP_SEARCH,
    OP_MUL,
    OP_ROUND,
    OP_DIV,
    OP_INTERP,
    OP_SETLOW,
    OP_SETOOR,
    OP_EMIT
  } op_e;

  typedef enum logic [2:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_LOW,
    COND_OOR,
    COND_SEARCH,
    COND_COUNT
  } cond_e;

  typedef struct packed {
    op_e   op;
    cond_e cond;
    pc_t   target;
    logic  last;
  } uword_t;

  typedef struct packed {
    logic load;
    op_e  op;
  } ctrl_t;

  typedef struct packed {
    logic low;
    logic oor;
    logic search_more;
    logic cnt_nz;
    logic out_full;
  } status_t;

  localparam pc_t PC_SCALE  = 4'd0;
  localparam pc_t PC_CHKLO  = 4'd1;
  localparam pc_t PC_CHKHI  = 4'd2;
  localparam pc_t PC_SEARCH = 4'd3;
  localparam pc_t PC_MUL    = 4'd4;
  localparam pc_t PC_ROUND  = 4'd5;
  localparam pc_t PC_DIV    = 4'd6;
  localparam pc_t PC_INTERP = 4'd7;
  localparam pc_t PC_SETLOW = 4'd8;
  localparam pc_t PC_SETOOR = 4'd9;
  localparam pc_t PC_EMIT   = 4'd10;

  // Calibration voltages in units of 0.1 mV.
  function automatic logic [VOLT_W-1:0] cal_volt(input idx_t i);
    logic [VOLT_W-1:0] v;
    case (i)
      4'd0:    v = 15'd10965;
      4'd1:    v = 15'd11223;
      4'd2:    v = 15'd13560;
      4'd3:    v = 15'd14830;
      4'd4:    v = 15'd15350;
      4'd5:    v = 15'd15616;
      4'd6:    v = 15'd15750;
      4'd7:    v = 15'd16710;
      4'd8:    v = 15'd17730;
      4'd9:    v = 15'd18760;
      4'd10:   v = 15'd20320;
      default: v = 15'd20865;
    endcase
    return v;
  endfunction

  // Calibration temperatures in units of 0.01 degC.
  function automatic logic signed [TEMP_W-1:0] cal_temp(input idx_t i);
    logic signed [TEMP_W-1:0] t;
    case (i)
      4'd0:    t = -21'sd4927;
      4'd1:    t = -21'sd4449;
      4'd2:    t = 21'sd0;
      4'd3:    t = 21'sd2000;
      4'd4:    t = 21'sd3344;
      4'd5:    t = 21'sd3861;
      4'd6:    t = 21'sd4000;
      4'd7:    t = 21'sd6000;
      4'd8:    t = 21'sd8000;
      4'd9:    t = 21'sd10000;
      4'd10:   t = 21'sd13045;
      default: t = 21'sd14111;
    endcase
    return t;
  endfunction

  // Microcode program: one control word per step.
  function automatic uword_t ucode(input pc_t pc);
    uword_t w;
    case (pc)
      PC_SCALE:  w = '{OP_SCALE,  COND_NEVER,  PC_SCALE,  1'b0};
      PC_CHKLO:  w = '{OP_NOP,    COND_LOW,    PC_SETLOW, 1'b0};
      PC_CHKHI:  w = '{OP_NOP,    COND_OOR,    PC_SETOOR, 1'b0};
      PC_SEARCH: w = '{OP_SEARCH, COND_SEARCH, PC_SEARCH, 1'b0};
      PC_MUL:    w = '{OP_MUL,    COND_NEVER,  PC_SCALE,  1'b0};
      PC_ROUND:  w = '{OP_ROUND,  COND_NEVER,  PC_SCALE,  1'b0};
      PC_DIV:    w = '{OP_DIV,    COND_COUNT,  PC_DIV,    1'b0};
      PC_INTERP: w = '{OP_INTERP, COND_ALWAYS, PC_EMIT,   1'b0};
      PC_SETLOW: w = '{OP_SETLOW, COND_ALWAYS, PC_EMIT,   1'b0};
      PC_SETOOR: w = '{OP_SETOOR, COND_NEVER,  PC_SCALE,  1'b0};
      PC_EMIT:   w = '{OP_EMIT,   COND_NEVER,  PC_SCALE,  1'b1};
      default:   w = '{OP_NOP,    COND_NEVER,  PC_SCALE,  1'b1};
    endcase
    return w;
  endfunction

endpackage

@@ design/rtd_lin_if.sv @@
// Request and result channel interfaces of the linearizer.
interface rtd_lin_in_if;
  import rtd_lin_pkg::*;
  logic              valid;
  logic              ready;
  logic [CODE_W-1:0] adc_code;
  modport source (output valid, output adc_code, input ready);
  modport sink (input valid, input adc_code, output ready);
endinterface

interface rtd_lin_out_if;
  import rtd_lin_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [TEMP_W-1:0] temp_centi;
  logic                     out_of_range;
  modport source (output valid, output temp_centi, output out_of_range, input ready);
  modport sink (input valid, input temp_centi, input out_of_range, output ready);
endinterface

@@ design/rtd_lin_seq.sv @@
// Microcode sequencer: step counter, control ROM and conditional jumps.
module rtd_lin_seq (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 accept_i,
  input  rtd_lin_pkg::status_t status_i,
  output rtd_lin_pkg::ctrl_t   ctrl_o,
  output logic                 ready_o
);
  import rtd_lin_pkg::*;

  pc_t    pc_q, pc_d;
  logic   busy_q, busy_d;
  uword_t uw;
  logic   hit;
  logic   stall;

  always_comb begin
    uw = ucode(pc_q);
    unique case (uw.cond)
      COND_NEVER:  hit = 1'b0;
      COND_ALWAYS: hit = 1'b1;
      COND_LOW:    hit = status_i.low;
      COND_OOR:    hit = status_i.oor;
      COND_SEARCH: hit = status_i.search_more;
      COND_COUNT:  hit = status_i.cnt_nz;
      default:     hit = 1'b0;
    endcase
    // The final step waits until the result register is free.
    stall = (uw.op == OP_EMIT) && status_i.out_full;

    ctrl_o.load = accept_i;
    ctrl_o.op   = (busy_q && !stall) ? uw.op : OP_NOP;

    pc_d   = pc_q;
    busy_d = busy_q;
    if (accept_i) begin
      pc_d   = PC_SCALE;
      busy_d = 1'b1;
    end else if (busy_q && !stall) begin
      if (uw.last) begin
        busy_d = 1'b0;
      end else if (hit) begin
        pc_d = uw.target;
      end else begin
        pc_d = pc_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q   <= PC_SCALE;
      busy_q <= 1'b0;
    end else begin
      pc_q   <= pc_d;
      busy_q <= busy_d;
    end
  end

  assign ready_o = !busy_q;

endmodule

@@ design/rtd_lin_datapath.sv @@
// Datapath: scaling multiplier, segment search, interpolation and divider.
module rtd_lin_datapath (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  rtd_lin_pkg::ctrl_t        ctrl_i,
  input  logic [rtd_lin_pkg::CODE_W-1:0] adc_code_i,
  output rtd_lin_pkg::status_t      status_o,
  rtd_lin_out_if.source             rsp_o
);
  import rtd_lin_pkg::*;

  logic [CODE_W-1:0]        code_q;
  logic [SC_W-1:0]          sc_q;
  idx_t                     lo_q, hi_q;
  logic [PROD_W-1:0]        prod_q;
  logic [PROD_W-1:0]        den_q;
  logic [QUO_W-1:0]         quo_q;
  logic [CNT_W-1:0]         cnt_q;
  logic signed [TEMP_W-1:0] temp_q;
  logic                     oor_q;
  logic                     valid_q;
  logic signed [TEMP_W-1:0] out_temp_q;
  logic                     out_oor_q;

  logic [IDX_W:0]           idx_sum;
  idx_t                     mid;
  logic [SC_W-1:0]          mid_thr;
  logic [SC_W-1:0]          lo_thr;
  logic [SC_W-1:0]          low_thr;
  logic [SC_W-1:0]          diff_full;
  logic [DIFF_W-1:0]        diff;
  logic signed [TEMP_W-1:0] dt_full;
  logic [DT_W-1:0]          dt;
  logic [VOLT_W-1:0]        dv_full;
  logic [DV_W-1:0]          dv;
  logic                     more;

  always_comb begin
    idx_sum   = {1'b0, lo_q} + {1'b0, hi_q};
    mid       = idx_sum[IDX_W:1];
    mid_thr   = {{(SC_W-VOLT_W-VOLT_SHIFT){1'b0}}, cal_volt(mid), {VOLT_SHIFT{1'b0}}};
    lo_thr    = {{(SC_W-VOLT_W-VOLT_SHIFT){1'b0}}, cal_volt(lo_q), {VOLT_SHIFT{1'b0}}};
    low_thr   = {{(SC_W-VOLT_W-VOLT_SHIFT){1'b0}}, cal_volt('0), {VOLT_SHIFT{1'b0}}};
    diff_full = sc_q - lo_thr;
    diff      = diff_full[DIFF_W-1:0];
    dt_full   = cal_temp(hi_q) - cal_temp(lo_q);
    dt        = dt_full[DT_W-1:0];
    dv_full   = cal_volt(hi_q) - cal_volt(lo_q);
    dv        = dv_full[DV_W-1:0];
    more      = ({1'b0, lo_q} + 1'b1) < {1'b0, hi_q};

    status_o.low         = sc_q <= low_thr;
    status_o.oor         = code_q >= CODE_FULL;
    status_o.search_more = more;
    status_o.cnt_nz      = cnt_q != '0;
    status_o.out_full    = valid_q && !rsp_o.ready;
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      code_q <= adc_code_i;
    end
    case (ctrl_i.op)
      OP_SCALE: begin
        sc_q <= {{(SC_W-CODE_W){1'b0}}, code_q} * {{(SC_W-13){1'b0}}, VOLT_SCALE};
        lo_q <= '0;
        hi_q <= idx_t'(TABLE_POINTS - 1);
      end
      OP_SEARCH: begin
        if (more) begin
          if (sc_q < mid_thr) begin
            hi_q <= mid;
          end else begin
            lo_q <= mid;
          end
        end
      end
      OP_MUL: begin
        prod_q <= {{(PROD_W-DIFF_W){1'b0}}, diff} * {{(PROD_W-DT_W){1'b0}}, dt};
      end
      OP_ROUND: begin
        prod_q <= prod_q + {{(PROD_W-DV_W-10){1'b0}}, dv, 10'b0};
        den_q  <= {{(PROD_W-DV_W-26){1'b0}}, dv, 26'b0};
        quo_q  <= '0;
        cnt_q  <= DIV_LAST;
      end
      OP_DIV: begin
        if (prod_q >= den_q) begin
          prod_q <= prod_q - den_q;
          quo_q  <= {quo_q[QUO_W-2:0], 1'b1};
        end else begin
          quo_q  <= {quo_q[QUO_W-2:0], 1'b0};
        end
        den_q <= den_q >> 1;
        cnt_q <= cnt_q - 1'b1;
      end
      OP_INTERP: begin
        temp_q <= cal_temp(lo_q) + $signed({{(TEMP_W-QUO_W){1'b0}}, quo_q});
        oor_q  <= 1'b0;
      end
      OP_SETLOW: begin
        temp_q <= cal_temp('0);
        oor_q  <= 1'b0;
      end
      OP_SETOOR: begin
        temp_q <= OOR_TEMP;
        oor_q  <= 1'b1;
      end
      OP_EMIT: begin
        out_temp_q <= temp_q;
        out_oor_q  <= oor_q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ctrl_i.op == OP_EMIT) begin
      valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      valid_q <= 1'b0;
    end
  end

  assign rsp_o.valid        = valid_q;
  assign rsp_o.temp_centi   = out_temp_q;
  assign rsp_o.out_of_range = out_oor_q;

endmodule

@@ design/rtd_temperature_linearizer_core.sv @@
// Top level of the RTD temperature linearizer.
//
// The block turns one raw 16-bit converter code into a temperature in signed
// hundredths of a degree Celsius, by piecewise-linear interpolation over a
// fixed 12-point calibration table. Requests arrive on req_i (adc_code) and
// results leave on rsp_o (temp_centi, out_of_range); each channel moves a
// request when valid and ready are high at a rising clock edge.
// One request is worked at a time. A microcoded sequencer runs the program:
// scale, two range checks, a binary search of three or four steps, a multiply,
// a rounding add, a 16-step restoring division and a final add. For a request
// that interpolates, the time from acceptance to a valid result depends on the
// search depth and is dominated by the division loop; clamped and out-of-range
// codes skip the search, multiply and division. req_i.ready rises again as the
// result is written into the output register, so the next request can be taken
// while that result waits.
// If the receiver stalls, the result holds in the output register and the
// sequencer waits at its last step until the register frees up.
// Reset (rst_ni low, asynchronous) empties the output register and returns
// the sequencer to idle with req_i.ready high.
`include "rtd_temperature_linearizer_core_assert.svh"

module rtd_temperature_linearizer_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  rtd_lin_in_if.sink   req_i,
  rtd_lin_out_if.source rsp_o
);
  import rtd_lin_pkg::*;

  ctrl_t   ctrl;
  status_t status;
  logic    seq_ready;
  logic    accept;

  // A request is taken only while the sequencer is idle.
  assign req_i.ready = seq_ready;
  assign accept      = req_i.valid && seq_ready;

  rtd_lin_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .status_i (status),
    .ctrl_o   (ctrl),
    .ready_o  (seq_ready)
  );

  rtd_lin_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (ctrl),
    .adc_code_i (req_i.adc_code),
    .status_o   (status),
    .rsp_o      (rsp_o)
  );

  // In the cycle after a request is taken, req_i.ready is low.
  `RTDLIN_ASSERT_NXT(a_busy_after_accept, clk_i, rst_ni, accept, !req_i.ready)
  // The out-of-range flag always comes with the sentinel temperature.
  `RTDLIN_ASSERT_IMP(a_oor_sentinel, clk_i, rst_ni, rsp_o.valid && rsp_o.out_of_range, rsp_o.temp_centi == OOR_TEMP)
  // An in-range result never falls below the clamp temperature.
  `RTDLIN_ASSERT_IMP(a_clamp_floor, clk_i, rst_ni, rsp_o.valid && !rsp_o.out_of_range, rsp_o.temp_centi >= cal_temp('0))

endmodule

@@ test/tb_rtd_temperature_linearizer_core.sv @@
// Self-checking testbench for the RTD temperature linearizer core.
`timescale 1ns / 100ps

module tb_rtd_temperature_linearizer_core;
  import rtd_lin_pkg::*;

  // Scaling of the converter code: volts = code * 3.3 / 16384. Voltages in the
  // calibration points are held in units of 0.1 mV, so the code is compared
  // as code * 33000 against volt * 16384, both exact integers.
  localparam longint VOLT_NUM  = 33000;
  localparam longint CODE_SPAN = 16384;

  // Handshake pacing and run limits.
  localparam int IDLE_PCT       = 29;
  localparam int RANDOM_ITEMS   = 800;
  localparam int HOLD_AT_ITEM   = 200;
  localparam int DRAIN_AT_ITEM  = 400;
  localparam int STEADY_FIRST   = 500;
  localparam int STEADY_LAST    = 620;
  localparam int HOLD_CYCLES    = 300;
  localparam int SETTLE_CYCLES  = 40;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DIRECTED_ROWS  = 21;

  // One expected reading: the code that caused it is kept for messages.
  typedef struct packed {
    logic [CODE_W-1:0]        code;
    logic signed [TEMP_W-1:0] temp;
    logic                     oor;
  } reading_t;

  // One row of the directed table. Where fixed_exp is set, temp and oor hold
  // the expected result; otherwise the row is checked against the predictor.
  typedef struct packed {
    logic [CODE_W-1:0]        code;
    logic                     fixed_exp;
    logic signed [TEMP_W-1:0] temp;
    logic                     oor;
  } stim_row_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  rtd_lin_in_if  req_if ();
  rtd_lin_out_if rsp_if ();

  rtd_temperature_linearizer_core uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // Readings still owed by the block, oldest first.
  reading_t  pending_readings[$];
  stim_row_t directed_rows [0:DIRECTED_ROWS-1];
  int        mismatches    = 0;
  // Set by the request side to ask the result side for one long hold-off.
  logic      hold_request  = 1'b0;
  // While set, neither side idles.
  logic      steady        = 1'b0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Calibration breakpoints: voltage in 0.1 mV and temperature in 0.01 degC.
  function automatic longint bp_volt(input int i);
    case (i)
      0:       return 10965;
      1:       return 11223;
      2:       return 13560;
      3:       return 14830;
      4:       return 15350;
      5:       return 15616;
      6:       return 15750;
      7:       return 16710;
      8:       return 17730;
      9:       return 18760;
      10:      return 20320;
      default: return 20865;
    endcase
  endfunction

  function automatic longint bp_temp(input int i);
    case (i)
      0:       return -4927;
      1:       return -4449;
      2:       return 0;
      3:       return 2000;
      4:       return 3344;
      5:       return 3861;
      6:       return 4000;
      7:       return 6000;
      8:       return 8000;
      9:       return 10000;
      10:      return 13045;
      default: return 14111;
    endcase
  endfunction

  // Works out the temperature that one converter code must produce.
  function automatic reading_t predict_reading(input logic [CODE_W-1:0] code);
    reading_t r;
    longint   scaled;
    longint   num;
    longint   den;
    longint   quo;
    int       lo;
    int       hi;
    int       mid;
    r.code = code;
    r.oor  = 1'b0;
    scaled = longint'(code) * VOLT_NUM;
    if (scaled <= bp_volt(0) * CODE_SPAN) begin
      // At or below the first point the result clamps, even for code 0.
      r.temp = TEMP_W'(bp_temp(0));
    end else if (code >= CODE_FULL) begin
      r.temp = OOR_TEMP;
      r.oor  = 1'b1;
    end else begin
      // Binary search for the segment; a voltage equal to an interior
      // breakpoint lands in the segment that starts there. Past the last
      // point the last segment is extended.
      lo = 0;
      hi = TABLE_POINTS - 1;
      while (lo < hi - 1) begin
        mid = (lo + hi) / 2;
        if (scaled < bp_volt(mid) * CODE_SPAN) begin
          hi = mid;
        end else begin
          lo = mid;
        end
      end
      num = (scaled - bp_volt(lo) * CODE_SPAN) * (bp_temp(hi) - bp_temp(lo));
      den = (bp_volt(hi) - bp_volt(lo)) * CODE_SPAN;
      // Round to the nearest hundredth, ties away from zero.
      if (num < 0) begin
        quo = -((-num + den / 2) / den);
      end else begin
        quo = (num + den / 2) / den;
      end
      r.temp = TEMP_W'(bp_temp(lo) + quo);
    end
    return r;
  endfunction

  // Offers one request, idling at random first, and records the expected
  // reading once the block has taken it.
  task automatic offer_code(input logic [CODE_W-1:0] code, input reading_t want);
    @(negedge clk_i);
    while (!steady && ($urandom_range(99) < IDLE_PCT)) begin
      req_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_if.valid    <= 1'b1;
    req_if.adc_code <= code;
    do begin
      @(posedge clk_i);
    end while (!req_if.ready);
    pending_readings.push_back(want);
  endtask

  // Result side: random back-pressure, one long hold-off on request, and a
  // stretch with ready held high.
  initial begin
    int hold_left;
    hold_left     = 0;
    rsp_if.ready  = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES - 1;
        rsp_if.ready <= 1'b0;
      end else if (steady) begin
        rsp_if.ready <= 1'b1;
      end else begin
        rsp_if.ready <= ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Every result that leaves the block is matched to the oldest expectation.
  always @(posedge clk_i) begin
    reading_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (pending_readings.size() == 0) begin
        $error("unexpected result: temp_centi %0d, out_of_range %0b",
               rsp_if.temp_centi, rsp_if.out_of_range);
        mismatches++;
      end else begin
        want = pending_readings.pop_front();
        if (rsp_if.temp_centi !== want.temp) begin
          $error("temp_centi mismatch for code %0d: expected %0d, actual %0d",
                 want.code, want.temp, rsp_if.temp_centi);
          mismatches++;
        end
        if (rsp_if.out_of_range !== want.oor) begin
          $error("out_of_range mismatch for code %0d: expected %0b, actual %0b",
                 want.code, want.oor, rsp_if.out_of_range);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: ends the run once nothing has moved on either channel for too
  // long. The long hold-off stays well inside the limit.
  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    @(posedge rst_ni);
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("rtd_temperature_linearizer_core test failed");
    $finish;
  end

  // Request side: reset, the directed table, then random codes.
  initial begin
    reading_t          want;
    logic [CODE_W-1:0] code;
    int                sel;
    int                k;
    req_if.valid    = 1'b0;
    req_if.adc_code = '0;

    // Directed rows: clamp edge, the first and last segments, codes on both
    // sides of several breakpoints, the top of the extrapolated range, the
    // range limit and alternating bit patterns.
    directed_rows = '{
      '{16'd0,     1'b1, -21'sd4927,  1'b0},
      '{16'd1,     1'b0, 21'sd0,      1'b0},
      '{16'd5443,  1'b1, -21'sd4927,  1'b0},
      '{16'd5444,  1'b0, 21'sd0,      1'b0},
      '{16'd5572,  1'b0, 21'sd0,      1'b0},
      '{16'd5573,  1'b0, 21'sd0,      1'b0},
      '{16'd6733,  1'b0, 21'sd0,      1'b0},
      '{16'd7363,  1'b0, 21'sd0,      1'b0},
      '{16'd7820,  1'b0, 21'sd0,      1'b0},
      '{16'd8191,  1'b0, 21'sd0,      1'b0},
      '{16'd10089, 1'b0, 21'sd0,      1'b0},
      '{16'd10359, 1'b0, 21'sd0,      1'b0},
      '{16'd10360, 1'b0, 21'sd0,      1'b0},
      '{16'd12288, 1'b0, 21'sd0,      1'b0},
      '{16'd16383, 1'b0, 21'sd0,      1'b0},
      '{16'd16384, 1'b1, 21'sd999900, 1'b1},
      '{16'd16385, 1'b1, 21'sd999900, 1'b1},
      '{16'd21845, 1'b1, 21'sd999900, 1'b1},
      '{16'd32768, 1'b1, 21'sd999900, 1'b1},
      '{16'd43690, 1'b1, 21'sd999900, 1'b1},
      '{16'd65535, 1'b1, 21'sd999900, 1'b1}
    };

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      if (directed_rows[i].fixed_exp) begin
        want.code = directed_rows[i].code;
        want.temp = directed_rows[i].temp;
        want.oor  = directed_rows[i].oor;
      end else begin
        want = predict_reading(directed_rows[i].code);
      end
      offer_code(directed_rows[i].code, want);
    end

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == HOLD_AT_ITEM) begin
        // The result side stalls for a long while; requests keep coming so
        // the block fills and pushes back on its input.
        hold_request = 1'b1;
      end
      if (n == DRAIN_AT_ITEM) begin
        // Stop offering until every outstanding result has come back.
        @(negedge clk_i);
        req_if.valid <= 1'b0;
        while (pending_readings.size() != 0) @(posedge clk_i);
      end
      steady = (n >= STEADY_FIRST) && (n < STEADY_LAST);

      // Mostly codes that interpolate, some in the clamp region, some near
      // breakpoints, and the rest across the whole 16-bit range.
      sel = $urandom_range(99);
      if (sel < 10) begin
        code = CODE_W'($urandom_range(5443));
      end else if (sel < 75) begin
        code = CODE_W'($urandom_range(16383, 5444));
      end else if (sel < 85) begin
        k    = $urandom_range(TABLE_POINTS - 1);
        code = CODE_W'((bp_volt(k) * 2048) / 4125 + $urandom_range(2) - 1);
      end else begin
        code = CODE_W'($urandom);
      end
      offer_code(code, predict_reading(code));
    end
    steady = 1'b0;

    @(negedge clk_i);
    req_if.valid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk_i);
    // A stray extra result would show up within one request's latency.
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("rtd_temperature_linearizer_core test passed");
    end else begin
      $display("rtd_temperature_linearizer_core test failed");
    end
    $finish;
  end

endmodule
